FILE: rtl/lpht_pkg.sv
// lpht_pkg: shared types and codes for the linear probing hash table
// transaction structs, slot entry layout, command, status and mark codes
// no dependencies
package lpht_pkg;

   localparam int DEFAULT_SLOTS = 256;
   localparam int HASH_W = 32;
   localparam int KEY_W = 32;
   localparam int VALUE_W = 64;
   localparam int FILL_W = 9;
   localparam logic [FILL_W-1:0] FILL_LIMIT_RESET = 9'd192;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_SEARCH = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_LIVE = 2'd1;
   localparam logic [1:0] MARK_TOMB = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [KEY_W-1:0]   key_id;
      logic [HASH_W-1:0]  key_hash;
      logic [VALUE_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] value_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         mark;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

endpackage

FILE: rtl/linear_probe_hash_table.sv
// linear_probe_hash_table: open addressing map, linear probing with tombstones
// a request runs the start slot modulo (mask for power-of-two SLOTS, else a
// reciprocal modulo), one probe step per slot and the done state; a search or
// delete with a zero fill count skips the probe; one slot read per cycle from the single
// read port of the slot memory; a new request waits for the last response
// reset: synchronous, then a clearing pass over all slots with req_ready low
module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS,
   localparam int IdxW = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [FILL_W-1:0] csr_data
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_MOD = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [IdxW-1:0]   clr_ff, clr_in;
   req_type           op_ff, op_in;
   logic [IdxW-1:0]   pos_ff, pos_in;
   logic [IdxW-1:0]   cnt_ff, cnt_in;
   logic              tomb_seen_ff, tomb_seen_in;
   logic [IdxW-1:0]   tomb_at_ff, tomb_at_in;
   logic [FILL_W-1:0] fill_count_ff, fill_count_in;
   logic [FILL_W-1:0] fill_limit_ff, fill_limit_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic            req_accept;
   logic            mod_done;
   logic [IdxW-1:0] mod_rem;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   slot_type        wr_data;
   logic            rd_en;
   logic [IdxW-1:0] rd_addr;
   slot_type        slot;

   logic            live, hit, tomb, empty, last, over, have_free;
   logic [IdxW-1:0] free_slot;
   logic [IdxW-1:0] pos_next;

   assign req_ready = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   lpht_mod #(.SLOTS(SLOTS)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .hash  (req_data.key_hash),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   lpht_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (slot)
   );

   // probe step decode
   assign live = (slot.mark == MARK_LIVE);
   assign hit = live && (slot.key == op_ff.key_id);
   assign tomb = (slot.mark == MARK_TOMB);
   assign empty = !live && !tomb;
   assign last = (cnt_ff == IdxW'(SLOTS - 1));
   assign have_free = empty || tomb || tomb_seen_ff;
   assign free_slot = tomb_seen_ff ? tomb_at_ff : pos_ff;
   assign over = ({1'b0, fill_count_ff} + (FILL_W+1)'(1)) > {1'b0, fill_limit_ff};
   assign pos_next = (pos_ff == IdxW'(SLOTS - 1)) ? '0 : pos_ff + IdxW'(1);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      op_in = op_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_at_in = tomb_at_ff;
      fill_count_in = fill_count_ff;
      fill_limit_in = fill_limit_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff;
      wr_data = '{mark: MARK_LIVE, key: op_ff.key_id, value: op_ff.value_in};
      rd_en = 1'b0;
      rd_addr = pos_ff;

      if (csr_valid) begin
         fill_limit_in = csr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '{mark: MARK_EMPTY, key: '0, value: '0};
            clr_in = clr_ff + IdxW'(1);
            if (clr_ff == IdxW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in = req_data;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               if (op_ff.cmd == CMD_INSERT ||
                   ((op_ff.cmd == CMD_SEARCH || op_ff.cmd == CMD_DELETE) &&
                    fill_count_ff != '0)) begin
                  pos_in = mod_rem;
                  cnt_in = '0;
                  tomb_seen_in = 1'b0;
                  rd_en = 1'b1;
                  rd_addr = mod_rem;
                  state_in = S_PROBE;
               end else begin
                  res_in = '{status: ST_MISS, value_out: '0};
                  state_in = S_DONE;
               end
            end
         end
         S_PROBE: begin
            res_in = '{status: ST_MISS, value_out: '0};
            if (hit) begin
               res_in.status = ST_OK;
               state_in = S_DONE;
               case (op_ff.cmd)
                  CMD_INSERT: begin
                     wr_en = 1'b1;
                  end
                  CMD_SEARCH: begin
                     res_in.value_out = slot.value;
                  end
                  CMD_DELETE: begin
                     wr_en = 1'b1;
                     wr_data = '{mark: MARK_TOMB, key: '0, value: '0};
                  end
                  default: begin
                     res_in.status = ST_MISS;
                  end
               endcase
            end else if (empty || last) begin
               state_in = S_DONE;
               if (op_ff.cmd == CMD_INSERT) begin
                  if (over || !have_free) begin
                     res_in.status = ST_FULL;
                  end else begin
                     res_in.status = ST_OK;
                     wr_en = 1'b1;
                     wr_addr = free_slot;
                     fill_count_in = fill_count_ff + FILL_W'(1);
                  end
               end
            end else begin
               if (tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_at_in = pos_ff;
               end
               pos_in = pos_next;
               cnt_in = cnt_ff + IdxW'(1);
               rd_en = 1'b1;
               rd_addr = pos_next;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         fill_count_ff <= '0;
         fill_limit_ff <= FILL_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         tomb_seen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         fill_count_ff <= fill_count_in;
         fill_limit_ff <= fill_limit_in;
         rsp_valid_ff <= rsp_valid_in;
         tomb_seen_ff <= tomb_seen_in;
      end
      op_ff <= op_in;
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      tomb_at_ff <= tomb_at_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memory writes only during the clearing pass or a probe step
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_CLEAR || state_ff == S_PROBE))
      else $error("slot write outside clear or probe");

   // fill count moves only on a probe step
   a_fill_stable: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff != S_PROBE) |=> $stable(fill_count_ff))
      else $error("fill count changed outside probe");

   // a new response transaction is loaded only from the done state
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (!reset && !rsp_valid_ff && rsp_valid_in) |-> state_ff == S_DONE)
      else $error("response loaded outside done state");

   // only a successful search carries a value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |-> rsp_data_ff.value_out == '0)
      else $error("nonzero value on failed transaction");

   // no request taken while a probe or the clearing pass is running
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE || state_ff == S_CLEAR) |-> !req_accept)
      else $error("request accepted while busy");

endmodule

FILE: rtl/lpht_mod.sv
// lpht_mod: start slot unit, key hash modulo the slot count
// registered mask for a power-of-two slot count, else reciprocal multiply, then back
// multiply, then one correcting subtract, each step registered; depends on lpht_pkg
module lpht_mod import lpht_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS,
   localparam int IdxW = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] hash,
   output logic              done,
   output logic [IdxW-1:0]   rem
);

   generate
      if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
         logic            done_ff;
         logic [IdxW-1:0] rem_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               rem_ff <= hash[IdxW-1:0];
            end
         end

         assign done = done_ff;
         assign rem = rem_ff;
      end else begin : g_recip
         localparam logic [2*HASH_W-1:0] RecipFull =
            ((2*HASH_W)'(1) << HASH_W) / (2*HASH_W)'(SLOTS);
         localparam logic [HASH_W-1:0] Recip = RecipFull[HASH_W-1:0];

         logic                step1_ff;
         logic                step2_ff;
         logic                done_ff;
         logic [HASH_W-1:0]   hash_ff;
         logic [HASH_W-1:0]   quot_ff;
         logic [IdxW:0]       part_ff;
         logic [IdxW-1:0]     rem_ff;
         logic [2*HASH_W-1:0] prod;
         logic [HASH_W-1:0]   back;
         logic [HASH_W-1:0]   diff;

         // quotient estimate is exact or one low, so the remainder is below 2 * SLOTS
         assign prod = (2*HASH_W)'(hash) * (2*HASH_W)'(Recip);
         assign back = quot_ff * HASH_W'(SLOTS);
         assign diff = hash_ff - back;

         always_ff @(posedge clock) begin
            if (reset) begin
               step1_ff <= 1'b0;
               step2_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               step1_ff <= start;
               step2_ff <= step1_ff;
               done_ff <= step2_ff;
            end
            if (start) begin
               hash_ff <= hash;
               quot_ff <= prod[2*HASH_W-1:HASH_W];
            end
            if (step1_ff) begin
               part_ff <= diff[IdxW:0];
            end
            if (step2_ff) begin
               if (part_ff >= (IdxW+1)'(SLOTS)) begin
                  rem_ff <= IdxW'(part_ff - (IdxW+1)'(SLOTS));
               end else begin
                  rem_ff <= part_ff[IdxW-1:0];
               end
            end
         end

         assign done = done_ff;
         assign rem = rem_ff;
      end
   endgenerate

endmodule

FILE: rtl/lpht_mem.sv
// lpht_mem: slot store, one write port and one registered read port
// each entry holds mark, key and value
// depends on lpht_pkg
module lpht_mem import lpht_pkg::*; #(
   parameter int SLOTS = DEFAULT_SLOTS,
   localparam int IdxW = $clog2(SLOTS)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IdxW-1:0] wr_addr,
   input  slot_type        wr_data,
   input  logic            rd_en,
   input  logic [IdxW-1:0] rd_addr,
   output slot_type        rd_data
);

   slot_type mem [SLOTS];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// tb_linear_probe_hash_table: self-checking bench for the linear probing hash table
// directed table then random phases under several fill limits, checked by a table mirror
// depends on lpht_pkg and linear_probe_hash_table
module tb_linear_probe_hash_table;
   import lpht_pkg::*;

   localparam int NSLOTS = DEFAULT_SLOTS;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int IDLE_PCT = 38;
   localparam int DRAIN_CYCLES = NSLOTS + 44;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      bit      typed;
      rsp_type rsp;
   } check_mode_type;

   typedef struct packed {
      bit                is_cfg;
      logic [FILL_W-1:0] limit;
      req_type           req;
      bit                typed;
      rsp_type           rsp;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [FILL_W-1:0] csr_data = '0;

   // mirror of the table contents
   logic [1:0]         mirror_mark [NSLOTS];
   logic [KEY_W-1:0]   mirror_key [NSLOTS];
   logic [VALUE_W-1:0] mirror_value [NSLOTS];
   logic [FILL_W-1:0]  mirror_fill;
   logic [FILL_W-1:0]  mirror_limit;

   rsp_type        pending_rsp [$];
   check_mode_type row_mode [$];
   stim_row_type   dir_rows [$];

   logic [KEY_W-1:0]  pool_key [NSLOTS];
   logic [HASH_W-1:0] pool_hash [NSLOTS];

   bit steady = 1'b0;
   int n_sent = 0;
   int n_done = 0;
   int n_ok = 0;
   int n_miss = 0;
   int n_full = 0;
   int errors = 0;
   int cycle_count = 0;

   linear_probe_hash_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   function automatic rsp_type predict_table_op(input req_type r);
      rsp_type     o;
      int unsigned pos;
      int unsigned hit_at;
      int unsigned tomb_at;
      int unsigned free_at;
      bit          hit;
      bit          have_free;
      bit          tomb_seen;
      bit          done;
      o.status = ST_MISS;
      o.value_out = '0;
      pos = r.key_hash % NSLOTS;
      hit = 1'b0;
      have_free = 1'b0;
      tomb_seen = 1'b0;
      done = 1'b0;
      hit_at = 0;
      tomb_at = 0;
      free_at = 0;
      for (int n = 0; n < NSLOTS && !done; n++) begin
         if (mirror_mark[pos] == MARK_LIVE) begin
            if (mirror_key[pos] == r.key_id) begin
               hit = 1'b1;
               hit_at = pos;
               done = 1'b1;
            end
         end else if (mirror_mark[pos] == MARK_TOMB) begin
            if (!tomb_seen) begin
               tomb_seen = 1'b1;
               tomb_at = pos;
            end
         end else begin
            have_free = 1'b1;
            free_at = tomb_seen ? tomb_at : pos;
            done = 1'b1;
         end
         pos = (pos + 1) % NSLOTS;
      end
      if (!done && tomb_seen) begin
         have_free = 1'b1;
         free_at = tomb_at;
      end
      case (r.cmd)
         CMD_INSERT: begin
            if (hit) begin
               mirror_value[hit_at] = r.value_in;
               o.status = ST_OK;
            end else if (mirror_fill + 1 > mirror_limit || !have_free) begin
               o.status = ST_FULL;
            end else begin
               mirror_mark[free_at] = MARK_LIVE;
               mirror_key[free_at] = r.key_id;
               mirror_value[free_at] = r.value_in;
               mirror_fill = mirror_fill + 1'b1;
               o.status = ST_OK;
            end
         end
         CMD_SEARCH: begin
            if (mirror_fill != 0 && hit) begin
               o.value_out = mirror_value[hit_at];
               o.status = ST_OK;
            end
         end
         CMD_DELETE: begin
            if (mirror_fill != 0 && hit) begin
               mirror_mark[hit_at] = MARK_TOMB;
               mirror_key[hit_at] = '0;
               mirror_value[hit_at] = '0;
               o.status = ST_OK;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic add_row(input bit typed, input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [HASH_W-1:0] hash, input logic [VALUE_W-1:0] val,
                          input logic [1:0] st, input logic [VALUE_W-1:0] vout);
      stim_row_type r;
      r = '0;
      r.req.cmd = cmd;
      r.req.key_id = key;
      r.req.key_hash = hash;
      r.req.value_in = val;
      r.typed = typed;
      r.rsp.status = st;
      r.rsp.value_out = vout;
      dir_rows.push_back(r);
   endtask

   task automatic add_limit(input logic [FILL_W-1:0] limit);
      stim_row_type r;
      r = '0;
      r.is_cfg = 1'b1;
      r.limit = limit;
      dir_rows.push_back(r);
   endtask

   task automatic send_item(input req_type item, input bit typed, input rsp_type fixed);
      check_mode_type mode;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      mode.typed = typed;
      mode.rsp = fixed;
      row_mode.push_back(mode);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
   endtask

   task automatic write_limit(input logic [FILL_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_data <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (n_done < n_sent) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : scoreboard
      check_mode_type mode;
      rsp_type        predicted;
      rsp_type        want;
      if (!reset) begin
         if (csr_valid && csr_ready) mirror_limit = csr_data;
         if (req_valid && req_ready) begin
            mode = row_mode.pop_front();
            predicted = predict_table_op(req_data);
            pending_rsp.push_back(mode.typed ? mode.rsp : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, got status %0d value %h",
                        $time, rsp_data.status, rsp_data.value_out);
            end else begin
               want = pending_rsp.pop_front();
               n_done++;
               case (want.status)
                  ST_OK:   n_ok++;
                  ST_MISS: n_miss++;
                  default: n_full++;
               endcase
               if (rsp_data.status !== want.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_data.status);
               end
               if (rsp_data.value_out !== want.value_out) begin
                  errors++;
                  $display("%0t: value_out mismatch, expected %h, got %h",
                           $time, want.value_out, rsp_data.value_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : main
      req_type    item;
      logic [7:0] base;
      int         lim;
      int         win;
      int         n_items;
      int         ins_pct;
      int         del_pct;
      int         roll;
      int         idx;

      for (int i = 0; i < NSLOTS; i++) begin
         mirror_mark[i] = MARK_EMPTY;
         mirror_key[i] = '0;
         mirror_value[i] = '0;
      end
      mirror_fill = '0;
      mirror_limit = FILL_LIMIT_RESET;

      // first 64 pool keys crowd into a dozen start slots to build long chains
      base = 8'($urandom_range(0, 255));
      for (int i = 0; i < NSLOTS; i++) begin
         pool_key[i] = $urandom;
         pool_hash[i] = $urandom;
         if (i < 64) pool_hash[i][7:0] = 8'(base + $urandom_range(0, 11));
      end

      // empty map and unused command
      add_row(1, CMD_SEARCH, 32'h0000_1234, 32'h0000_0040, '0, ST_MISS, '0);
      add_row(1, CMD_DELETE, 32'h0000_1234, 32'h0000_0040, '1, ST_MISS, '0);
      add_row(1, CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, ST_MISS, '0);
      // field extremes
      add_row(1, CMD_INSERT, 32'h0000_0000, 32'h0000_0000, '0, ST_OK, '0);
      add_row(1, CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, ST_OK, '0);
      add_row(1, CMD_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, ST_OK, '1);
      // collisions and wrap past the last slot
      add_row(0, CMD_INSERT, 32'h0000_0001, 32'h0000_0100, 64'hA5A5_0000_5A5A_FFFF, ST_OK, '0);
      add_row(0, CMD_INSERT, 32'h0000_0002, 32'h0000_01FF, 64'h0F0F_F0F0_1234_5678, ST_OK, '0);
      add_row(0, CMD_SEARCH, 32'h0000_0002, 32'h0000_01FF, '0, ST_OK, '0);
      // overwrite of an existing key
      add_row(1, CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 64'h0123_4567_89AB_CDEF, ST_OK, '0);
      add_row(0, CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, '0, ST_OK, '0);
      // delete, probe past the tombstone, reuse it
      add_row(1, CMD_DELETE, 32'h0000_0000, 32'h0000_0000, '0, ST_OK, '0);
      add_row(0, CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, '0, ST_OK, '0);
      add_row(0, CMD_SEARCH, 32'h0000_0001, 32'h0000_0100, '0, ST_OK, '0);
      add_row(0, CMD_DELETE, 32'h0000_0000, 32'h0000_0000, '0, ST_OK, '0);
      add_row(0, CMD_INSERT, 32'h0000_0003, 32'h0000_0200, 64'hDEAD_BEEF_CAFE_F00D, ST_OK, '0);
      add_row(0, CMD_SEARCH, 32'h0000_0003, 32'h0000_0200, '0, ST_OK, '0);
      add_row(1, CMD_UNUSED, 32'h0000_0001, 32'h0000_0100, '1, ST_MISS, '0);
      add_row(0, CMD_SEARCH, 32'h0000_0001, 32'h0000_0100, '0, ST_OK, '0);
      // lowest limit: new key is refused, existing key still overwrites
      add_limit(9'd1);
      add_row(1, CMD_INSERT, 32'h0000_5A5A, 32'h0000_0033, '1, ST_FULL, '0);
      add_row(1, CMD_INSERT, 32'h0000_0001, 32'h0000_0100, 64'h1, ST_OK, '0);
      add_row(1, CMD_SEARCH, 32'h0000_5A5A, 32'h0000_0033, '0, ST_MISS, '0);
      add_row(0, CMD_SEARCH, 32'h0000_0001, 32'h0000_0100, '0, ST_OK, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].is_cfg) begin
            wait_drained();
            write_limit(dir_rows[i].limit);
         end else begin
            send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
         end
      end

      for (int p = 0; p < 4; p++) begin
         wait_drained();
         case (p)
            0: begin
               lim = mirror_fill + 40;
               win = 24;
               n_items = 180;
               ins_pct = 40;
               del_pct = 20;
            end
            1: begin
               lim = mirror_fill;
               win = 32;
               n_items = 60;
               ins_pct = 40;
               del_pct = 20;
            end
            2: begin
               lim = 255;
               win = 64;
               n_items = 180;
               ins_pct = 40;
               del_pct = 20;
            end
            default: begin
               lim = 256;
               win = NSLOTS;
               n_items = 230;
               ins_pct = 65;
               del_pct = 10;
            end
         endcase
         if (lim < 1) lim = 1;
         if (lim > 256) lim = 256;
         write_limit(lim[FILL_W-1:0]);
         for (int i = 0; i < n_items; i++) begin
            steady = (p == 2 && i < 60);
            item = '0;
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               item.cmd = 2'($urandom_range(0, 3));
               item.key_id = $urandom;
               item.key_hash = $urandom;
            end else begin
               idx = $urandom_range(0, win - 1);
               item.key_id = pool_key[idx];
               item.key_hash = pool_hash[idx];
               roll = $urandom_range(0, 99);
               if (roll < ins_pct) item.cmd = CMD_INSERT;
               else if (roll < ins_pct + del_pct) item.cmd = CMD_DELETE;
               else if (roll < 95) item.cmd = CMD_SEARCH;
               else item.cmd = CMD_UNUSED;
            end
            item.value_in = {$urandom, $urandom};
            send_item(item, 1'b0, '0);
         end
      end
      steady = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d transactions, checked %0d responses: %0d ok, %0d not found, %0d full",
               n_sent, n_done, n_ok, n_miss, n_full);
      $display("fill limit swept from 1 to 256, final fill count %0d, %0d mismatches",
               mirror_fill, errors);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: linear_probe_hash_table.f
rtl/lpht_pkg.sv
rtl/lpht_mod.sv
rtl/lpht_mem.sv
rtl/linear_probe_hash_table.sv
tb/tb_linear_probe_hash_table.sv
